### src/kam_pkg.sv
// ----------------------------------------------------------------------------
// kam_pkg
// Shared types and codes of the keyed aggregation merge block.
// ----------------------------------------------------------------------------
package kam_pkg;

  // result status codes
  localparam logic [2:0] StCreated  = 3'd0;
  localparam logic [2:0] StUpdated  = 3'd1;
  localparam logic [2:0] StInvalid  = 3'd2;
  localparam logic [2:0] StFull     = 3'd3;
  localparam logic [2:0] StNotFound = 3'd4;

  // aggregation type codes
  localparam logic [2:0] TCount = 3'd0;
  localparam logic [2:0] TSum   = 3'd1;
  localparam logic [2:0] TAvg   = 3'd2;
  localparam logic [2:0] TStd   = 3'd3;
  localparam logic [2:0] TMin   = 3'd4;
  localparam logic [2:0] TMax   = 3'd5;

  // configuration register indexes
  localparam logic RegAggCount = 1'b0;
  localparam logic RegAggTypes = 1'b1;

  localparam int unsigned KeyBytes = 8;

  // one stored entry: tag plus accumulators
  typedef struct packed {
    logic [2:0]  agg;
    logic [63:0] key;
    logic [63:0] cnt;
    logic [63:0] val;
    logic [63:0] sql;
    logic [63:0] sqh;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

endpackage

### src/kam_ram.sv
// ----------------------------------------------------------------------------
// kam_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module kam_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule

### src/kam_alu.sv
// ----------------------------------------------------------------------------
// kam_alu
// Shared 64-bit adder/compare unit: accumulates one entry field per step.
// ----------------------------------------------------------------------------
module kam_alu (
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  input  logic        cin_i,
  input  logic        min_i,
  input  logic        max_i,
  output logic [63:0] res_o,
  output logic        cout_o
);
  logic [64:0] sum;
  logic        b_lt_a;

  always_comb begin
    sum    = {1'b0, a_i} + {1'b0, b_i} + {64'd0, cin_i};
    b_lt_a = $signed(b_i) < $signed(a_i);
    cout_o = sum[64];
    if (min_i) begin
      res_o = b_lt_a ? b_i : a_i;
    end else if (max_i) begin
      res_o = (!b_lt_a && b_i != a_i) ? b_i : a_i;
    end else begin
      res_o = sum[63:0];
    end
  end
endmodule

### src/keyed_aggregation_merge.sv
// ----------------------------------------------------------------------------
// keyed_aggregation_merge
// Keyed aggregation table: merges or looks up records by aggregation and key.
// ----------------------------------------------------------------------------
// One record at a time. After reset the valid bits clear at once. A record
// with a bad header gives its result straight from the check state. Otherwise
// the sequencer scans the table through the entry RAM's single port, one slot
// per cycle, and stops early on a hit. A hit then rereads the entry (states
// RD and RDW). A lookup ends there. A merge makes four passes through the
// shared 64-bit adder and one write-back. The result sits in an output
// register. The next record is taken only after the result has been accepted
// and the sequencer is back in idle.
module keyed_aggregation_merge #(
  parameter int unsigned TABLE_ENTRIES    = 256,
  parameter int unsigned MAX_AGGREGATIONS = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // configuration write channel
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic         cfg_index_i,
  input  logic [23:0]  cfg_data_i,
  // input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: header[31:0], key_value[95:32], amount[159:96], count_add[223:160],
  //        squares_low[287:224], squares_high[351:288]
  input  logic [351:0] s_axis_tdata,
  input  logic         s_axis_tuser,  // command
  // result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: status[2:0], entry_count[66:3], entry_value[130:67],
  //        entry_squares_low[194:131], entry_squares_high[258:195], zero fill
  output logic [263:0] m_axis_tdata
);
  import kam_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_ENTRIES);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_RD    = 4'd3;
  localparam logic [3:0] S_RDW   = 4'd4;
  localparam logic [3:0] S_CNT   = 4'd5;
  localparam logic [3:0] S_VAL   = 4'd6;
  localparam logic [3:0] S_SQL   = 4'd7;
  localparam logic [3:0] S_SQH   = 4'd8;
  localparam logic [3:0] S_WR    = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0]  state_q, state_d;
  logic [3:0]  agg_cnt_q;
  logic [23:0] agg_types_q;
  logic [TABLE_ENTRIES-1:0] valid_q;

  // captured record
  logic        cmd_q;
  logic [2:0]  idx_q, ctype_q;
  logic [63:0] key_q, amt_q, cadd_q, sql_in_q, sqh_in_q;
  logic        hdr_ok;

  // scan bookkeeping
  logic [AW:0]   scan_q;        // address issued, one wider for the end
  logic          rd_pend_q;
  logic [AW-1:0] rd_addr_q;
  logic          hit_q, free_q;
  logic [AW-1:0] hit_addr_q, free_addr_q;
  logic          slot_hit;

  // working entry and result
  entry_t      ent_q;
  logic        carry_q;
  logic [2:0]  status_q;
  logic        have_q;
  logic        out_valid_q;

  // ram port
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  entry_t        ram_rd;

  // alu port
  logic [63:0] alu_a, alu_b, alu_res;
  logic        alu_cin, alu_min, alu_max, alu_cout;

  kam_ram #(.Width(EntryW), .Depth(TABLE_ENTRIES)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ent_q),
    .rdata_o(ram_rd)
  );

  kam_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .cin_i (alu_cin),
    .min_i (alu_min),
    .max_i (alu_max),
    .res_o (alu_res),
    .cout_o(alu_cout)
  );

  assign cfg_ready_o   = (state_q == S_IDLE) && !out_valid_q;
  assign s_axis_tready = (state_q == S_IDLE) && !out_valid_q;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0,
                          have_q ? ent_q.sqh : 64'd0, have_q ? ent_q.sql : 64'd0,
                          have_q ? ent_q.val : 64'd0, have_q ? ent_q.cnt : 64'd0,
                          status_q};

  // slot read last cycle matches the record
  assign slot_hit = rd_pend_q && !hit_q && valid_q[rd_addr_q] &&
                    (ram_rd.agg == idx_q) && (ram_rd.key == key_q);

  // header check against captured record
  logic [15:0] hidx;
  logic [11:0] hunits;
  logic [3:0]  htype;
  logic [2:0]  cfg_t;
  logic [31:0] hdr_q;
  always_comb begin
    hidx   = hdr_q[15:0];
    hunits = hdr_q[27:16];
    htype  = hdr_q[31:28];
    cfg_t  = agg_types_q[3*idx_q +: 3];
    hdr_ok = (hidx < {12'd0, agg_cnt_q}) && (hidx < 16'(MAX_AGGREGATIONS))
             && (cfg_t <= TMax) && ({1'b0, cfg_t} == htype)
             && ({hunits, 3'd0} == 15'(KeyBytes));
  end

  // ALU operand selection per update step
  always_comb begin
    alu_a   = 64'd0;
    alu_b   = 64'd0;
    alu_cin = 1'b0;
    alu_min = 1'b0;
    alu_max = 1'b0;
    case (state_q)
      S_CNT: begin
        alu_a = ent_q.cnt;
        alu_b = (ctype_q == TCount) ? amt_q : cadd_q;
      end
      S_VAL: begin
        alu_a   = ent_q.val;
        alu_b   = amt_q;
        alu_min = ctype_q == TMin;
        alu_max = ctype_q == TMax;
      end
      S_SQL: begin
        alu_a = ent_q.sql;
        alu_b = sql_in_q;
      end
      S_SQH: begin
        alu_a   = ent_q.sqh;
        alu_b   = sqh_in_q;
        alu_cin = carry_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    ram_we   = (state_q == S_WR);
    ram_addr = (state_q == S_SCAN) ? scan_q[AW-1:0] :
               (state_q == S_WR && !hit_q) ? free_addr_q : hit_addr_q;
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (s_axis_tvalid && s_axis_tready) state_d = S_CHECK;
      S_CHECK: state_d = hdr_ok ? S_SCAN : S_OUT;
      S_SCAN:  if (!rd_pend_q && scan_q == (AW+1)'(TABLE_ENTRIES)) begin
        if (hit_q)                 state_d = cmd_q ? S_RD : S_RD;
        else if (cmd_q || !free_q) state_d = S_OUT;
        else                       state_d = S_CNT;
      end
      S_RD:    state_d = S_RDW;
      S_RDW:   state_d = cmd_q ? S_OUT : S_CNT;
      S_CNT:   state_d = S_VAL;
      S_VAL:   state_d = S_SQL;
      S_SQL:   state_d = S_SQH;
      S_SQH:   state_d = S_WR;
      S_WR:    state_d = S_OUT;
      S_OUT:   if (!out_valid_q) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      agg_cnt_q   <= 4'd1;
      agg_types_q <= 24'd0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
      scan_q      <= '0;
      rd_pend_q   <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == RegAggCount) agg_cnt_q <= cfg_data_i[3:0];
        else                            agg_types_q <= cfg_data_i;
      end
      if (m_axis_tvalid && m_axis_tready) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          scan_q    <= '0;
          rd_pend_q <= 1'b0;
          hit_q     <= 1'b0;
          free_q    <= 1'b0;
        end
        S_CHECK: if (!hdr_ok) begin
          out_valid_q <= 1'b1;
        end
        S_SCAN: begin
          if (slot_hit) begin
            // match found: stop issuing reads
            hit_q     <= 1'b1;
            scan_q    <= (AW+1)'(TABLE_ENTRIES);
            rd_pend_q <= 1'b0;
          end else begin
            // issue next address, check the slot read last cycle
            if (!hit_q && scan_q != (AW+1)'(TABLE_ENTRIES)) begin
              scan_q    <= scan_q + 1'b1;
              rd_pend_q <= 1'b1;
            end else begin
              rd_pend_q <= 1'b0;
            end
            if (rd_pend_q && !hit_q && !valid_q[rd_addr_q] && !free_q) begin
              free_q <= 1'b1;
            end
          end
          if (state_d == S_OUT) out_valid_q <= 1'b1;
        end
        S_RDW: if (cmd_q) out_valid_q <= 1'b1;
        S_WR: begin
          valid_q[hit_q ? hit_addr_q : free_addr_q] <= 1'b1;
          out_valid_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
        cmd_q    <= s_axis_tuser;
        hdr_q    <= s_axis_tdata[31:0];
        idx_q    <= s_axis_tdata[2:0];
        key_q    <= s_axis_tdata[95:32];
        amt_q    <= s_axis_tdata[159:96];
        cadd_q   <= s_axis_tdata[223:160];
        sql_in_q <= s_axis_tdata[287:224];
        sqh_in_q <= s_axis_tdata[351:288];
      end
      S_CHECK: begin
        ctype_q  <= agg_types_q[3*idx_q +: 3];
        status_q <= StInvalid;
        have_q   <= 1'b0;
      end
      S_SCAN: begin
        rd_addr_q <= scan_q[AW-1:0];
        if (rd_pend_q && !hit_q) begin
          if (valid_q[rd_addr_q]) begin
            if (ram_rd.agg == idx_q && ram_rd.key == key_q) hit_addr_q <= rd_addr_q;
          end else if (!free_q) begin
            free_addr_q <= rd_addr_q;
          end
        end
        if (state_d == S_OUT) begin
          status_q <= cmd_q ? StNotFound : StFull;
          have_q   <= 1'b0;
        end
        if (state_d == S_CNT) begin
          // new entry starts from zero accumulators
          ent_q    <= '{agg: idx_q, key: key_q, cnt: '0, val: '0, sql: '0, sqh: '0};
          status_q <= StCreated;
          have_q   <= 1'b1;
        end
      end
      S_RDW: begin
        ent_q    <= ram_rd;
        status_q <= StUpdated;
        have_q   <= 1'b1;
      end
      S_CNT: if (ctype_q == TCount || ctype_q == TAvg || ctype_q == TStd) begin
        ent_q.cnt <= alu_res;
      end
      S_VAL: if (ctype_q != TCount) begin
        // new min/max entries take the amount outright
        ent_q.val <= (!hit_q && (ctype_q == TMin || ctype_q == TMax)) ? amt_q : alu_res;
      end
      S_SQL: begin
        carry_q <= alu_cout;
        if (ctype_q == TStd) ent_q.sql <= alu_res;
      end
      S_SQH: if (ctype_q == TStd) ent_q.sqh <= alu_res;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  // no result is offered while a record is being scanned
  a_no_out_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> !out_valid_q) else $error("result during scan");
  // write-back only to a slot reached through a hit or a free slot
  a_wr_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WR) |-> (hit_q || free_q)) else $error("write without target");
  // the slot written is valid afterwards
  a_wr_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WR) |=> valid_q[$past(ram_addr)]) else $error("slot not valid");
  // a lookup never writes the table
  a_lookup_ro: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we) |-> !cmd_q) else $error("lookup wrote table");
`endif
endmodule
